@@ rtl/slft_pkg.sv @@
// ----------------------------------------------------------------------------
// slft_pkg: shared types and constants for the serial line frame transmitter
// Frame kinds, register indexes, reset values and the control bundles that
// run between the controller and the datapath.
// ----------------------------------------------------------------------------
package slft_pkg;

   // frame kinds
   localparam logic MODE_BARE = 1'b0;
   localparam logic MODE_UART = 1'b1;

   // default and fixed widths
   localparam int WORD_BITS_DEF = 32;
   localparam int VALUE_W       = 32;
   localparam int UART_BITS     = 8;
   localparam int PERIOD_W      = 16;
   localparam int MS_W          = 24;

   // register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_MS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLK_PER_MS = 1'b1;

   localparam logic [PERIOD_W-1:0] PERIOD_MS_RST  = 16'd1;
   localparam logic [MS_W-1:0]     CLK_PER_MS_RST = 24'd50000;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture a new word and clear the timers
      logic tick;   // advance the bit-time timers
      logic emit;   // push the current bit into the output register
   } slft_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bit_done;  // bit time has run out
      logic out_free;  // output register can take a word this cycle
      logic is_last;   // current bit is the final one of the frame
   } slft_stat_type;

endpackage

@@ rtl/slft_req_if.sv @@
// ----------------------------------------------------------------------------
// slft_req_if: request channel
// Carries the frame kind and the value to send, with valid/ready.
// ----------------------------------------------------------------------------
interface slft_req_if
   import slft_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               op;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

@@ rtl/slft_rsp_if.sv @@
// ----------------------------------------------------------------------------
// slft_rsp_if: response channel
// One word per bit time: the line level and an end-of-frame flag.
// ----------------------------------------------------------------------------
interface slft_rsp_if;
   logic valid;
   logic ready;
   logic line_level;
   logic last;

   modport source (output valid, output line_level, output last, input ready);
   modport sink   (input valid, input line_level, input last, output ready);
endinterface

@@ rtl/slft_ctrl.sv @@
// ----------------------------------------------------------------------------
// slft_ctrl: frame sequencer
// Takes a request, times each bit and hands each bit to the datapath.
// ----------------------------------------------------------------------------
module slft_ctrl
   import slft_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output slft_cmd_type  cmd,
   input  slft_stat_type stat
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_TIME = 3'b010,
      ST_SEND = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_TIME;
            end
         end
         ST_TIME: begin
            cmd.tick = 1'b1;
            if (stat.bit_done) state_in = ST_SEND;
         end
         ST_SEND: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = stat.is_last ? ST_IDLE : ST_TIME;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ rtl/slft_dp.sv @@
// ----------------------------------------------------------------------------
// slft_dp: transmitter datapath
// Registers, shift register, bit-time timers and the output word register.
// ----------------------------------------------------------------------------
module slft_dp
   import slft_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_op,
   input  logic [VALUE_W-1:0]    req_value,
   input  slft_cmd_type          cmd,
   output slft_stat_type         stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_line_level,
   output logic                  rsp_last
);

   localparam int DATA_W  = (WORD_BITS > UART_BITS) ? WORD_BITS : UART_BITS;
   localparam int BARE_LAST = WORD_BITS + 1;
   localparam int UART_LAST = UART_BITS + 1;
   localparam int MAX_IDX = (BARE_LAST > UART_LAST) ? BARE_LAST : UART_LAST;
   localparam int IDX_W   = $clog2(MAX_IDX + 1);

   logic [PERIOD_W-1:0] period_ms_ff;
   logic [MS_W-1:0]     clk_per_ms_ff;
   logic [DATA_W-1:0]   shift_ff, shift_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [MS_W-1:0]     ms_cnt_ff, ms_cnt_in;
   logic [PERIOD_W-1:0] per_cnt_ff, per_cnt_in;
   logic                op_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_level_ff, rsp_last_ff;

   logic             ms_done, per_done, bit_level;
   logic [IDX_W-1:0] last_idx;
   logic [DATA_W-1:0] load_data;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ms_ff  <= PERIOD_MS_RST;
         clk_per_ms_ff <= CLK_PER_MS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PERIOD_MS:  period_ms_ff  <= csr_wdata[PERIOD_W-1:0];
            CSR_CLK_PER_MS: clk_per_ms_ff <= csr_wdata[MS_W-1:0];
            default: ;
         endcase
      end
   end

   // bit-time timers: ms prescaler feeding a millisecond counter
   assign ms_done  = (clk_per_ms_ff == '0) || (ms_cnt_ff == clk_per_ms_ff - MS_W'(1));
   assign per_done = (period_ms_ff == '0) || (per_cnt_ff == period_ms_ff - PERIOD_W'(1));

   assign last_idx = (op_ff == MODE_UART) ? IDX_W'(UART_LAST) : IDX_W'(BARE_LAST);

   always_comb begin
      if (req_op == MODE_UART) load_data = DATA_W'(req_value[UART_BITS-1:0]);
      else                     load_data = DATA_W'(req_value[WORD_BITS-1:0]);
   end

   // start bit low, stop bit low for bare frames and high for uart
   always_comb begin
      if (idx_ff == '0)            bit_level = 1'b0;
      else if (idx_ff == last_idx) bit_level = (op_ff == MODE_UART);
      else                         bit_level = shift_ff[0];
   end

   always_comb begin
      shift_in   = shift_ff;
      idx_in     = idx_ff;
      ms_cnt_in  = ms_cnt_ff;
      per_cnt_in = per_cnt_ff;
      if (cmd.load) begin
         shift_in   = load_data;
         idx_in     = '0;
         ms_cnt_in  = '0;
         per_cnt_in = '0;
      end else if (cmd.emit) begin
         if (idx_ff != '0) shift_in = shift_ff >> 1;
         idx_in = (idx_ff == last_idx) ? '0 : idx_ff + IDX_W'(1);
      end else if (cmd.tick) begin
         if (ms_done) begin
            ms_cnt_in  = '0;
            per_cnt_in = per_done ? '0 : per_cnt_ff + PERIOD_W'(1);
         end else begin
            ms_cnt_in = ms_cnt_ff + MS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         ms_cnt_ff  <= '0;
         per_cnt_ff <= '0;
         op_ff      <= MODE_BARE;
      end else begin
         idx_ff     <= idx_in;
         ms_cnt_ff  <= ms_cnt_in;
         per_cnt_ff <= per_cnt_in;
         if (cmd.load) op_ff <= req_op;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   // output word register
   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign stat.bit_done = ms_done && per_done;
   assign stat.is_last  = (idx_ff == last_idx);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit)     rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_level_ff <= bit_level;
         rsp_last_ff  <= stat.is_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_level = rsp_level_ff;
   assign rsp_last       = rsp_last_ff;

   // a bit is only pushed when the output register has room
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("bit pushed into a full output register");

   // bit index never runs past the stop bit
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= last_idx)
      else $error("bit index beyond frame end");

   // the stop bit returns the sequencer to the frame start
   a_last_wrap: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && stat.is_last) |=> (idx_ff == '0) && rsp_valid && rsp_last)
      else $error("frame end did not wrap the bit index");

   // a new word starts with cleared timers
   a_load_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (ms_cnt_ff == '0) && (per_cnt_ff == '0) && (idx_ff == '0))
      else $error("timers not cleared at frame start");

endmodule

@@ rtl/serial_line_frame_transmitter_top.sv @@
// ----------------------------------------------------------------------------
// serial_line_frame_transmitter_top: serial line frame transmitter
// Sends one value per request as a frame of bit times, one response word each.
// ----------------------------------------------------------------------------
// Each request word becomes a frame of response words, one per bit time, LSB
// first. Op 0 sends a bare frame of WORD_BITS + 2 bit times (low start, data,
// low stop); op 1 sends uart 8n1 on the low byte, 10 bit times (low start,
// 8 data, high stop). Each bit time is set by a millisecond prescaler counting
// clk_per_ms and a bit-time counter counting period_ms; once both run out the
// sequencer hands the bit to the output word register. One frame is in flight
// at a time: req_ready is high only between frames, and the next request is
// taken while the last response word of the previous frame still sits in
// the output register. Registers are written through csr_we / csr_index /
// csr_wdata (0 period_ms, 1 clk_per_ms) and should only change between
// frames.
// ----------------------------------------------------------------------------
module serial_line_frame_transmitter_top
   import slft_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   slft_req_if.sink              req_chan,
   slft_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // command and status between sequencer and datapath
   slft_cmd_type  cmd;
   slft_stat_type stat;

   slft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // word capture, timers and output word register
   slft_dp #(
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_op         (req_chan.op),
      .req_value      (req_chan.value),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_line_level (rsp_chan.line_level),
      .rsp_last       (rsp_chan.last)
   );

endmodule

@@ bench/serial_line_frame_transmitter_top_tb.sv @@
// ----------------------------------------------------------------------------
// serial_line_frame_transmitter_top_tb: self-checking bench for the frame sender
// Sends bare and uart frames over the request channel and checks every line
// word that comes back, level and end flag, against a frame builder kept in
// the bench. Bit timing is set small through the register port, with one
// long uart frame at the largest period, and both channels stall at random.
// ----------------------------------------------------------------------------
module serial_line_frame_transmitter_top_tb;
   import slft_pkg::*;

   localparam int FRAME_DATA_BITS = WORD_BITS_DEF;
   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int DRAIN_CYCLES    = 20;

   // one request word as the sender queues it
   typedef struct packed {
      logic               op;
      logic [VALUE_W-1:0] value;
   } frame_req_type;

   // one bit time on the line as it should come back
   typedef struct packed {
      logic level;
      logic last;
   } line_word_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   slft_req_if req_chan ();
   slft_rsp_if rsp_chan ();

   serial_line_frame_transmitter_top #(
      .WORD_BITS (FRAME_DATA_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // frames waiting to be offered, and line words still owed by the block
   frame_req_type frame_q[$];
   line_word_type line_q[$];

   // bench copy of the bit-time registers; they only stretch the bit time
   logic [PERIOD_W-1:0] cfg_period_ms  = PERIOD_MS_RST;
   logic [MS_W-1:0]     cfg_clk_per_ms = CLK_PER_MS_RST;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  frames_queued = 0;
   int  frames_taken  = 0;
   int  bare_frames   = 0;
   int  uart_frames   = 0;
   int  words_checked = 0;
   int  err_count     = 0;
   int  settings_run  = 0;
   int  cycle_count   = 0;
   bit  req_taken     = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      err_count++;
   endtask

   // build the line words of one frame: low start, data lsb first, stop bit
   // (low for a bare frame, high for uart); the return to idle is no word
   function automatic void build_frame(input logic op, input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] shreg;
      int                 nbits;
      if (op == MODE_BARE) begin
         nbits = FRAME_DATA_BITS;
         shreg = (FRAME_DATA_BITS >= VALUE_W) ? value
                 : (value & ((VALUE_W'(1) << FRAME_DATA_BITS) - VALUE_W'(1)));
         bare_frames++;
      end else begin
         nbits = UART_BITS;
         shreg = value & VALUE_W'(8'hFF);
         uart_frames++;
      end
      line_q.push_back('{level: 1'b0, last: 1'b0});
      for (int i = 0; i < nbits; i++) begin
         line_q.push_back('{level: shreg[0], last: 1'b0});
         shreg = shreg >> 1;
      end
      line_q.push_back('{level: (op == MODE_UART), last: 1'b1});
   endfunction

   // ------------------------------------------------------------------------
   // monitor: check line words and predict frames at the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      line_word_type want;
      // tells the driver whether its word went in at this edge
      req_taken = !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (line_q.size() == 0) begin
               report_mismatch($sformatf("line word level=%0b last=%0b with none owed",
                                         rsp_chan.line_level, rsp_chan.last));
            end else begin
               want = line_q.pop_front();
               if (rsp_chan.line_level !== want.level)
                  report_mismatch($sformatf("line level %0b, wanted %0b (word %0d)",
                                            rsp_chan.line_level, want.level, words_checked));
               if (rsp_chan.last !== want.last)
                  report_mismatch($sformatf("last flag %0b, wanted %0b (word %0d)",
                                            rsp_chan.last, want.last, words_checked));
               words_checked++;
            end
         end
         // a frame is taken while the previous last word may still be leaving,
         // so new words go behind whatever is still owed
         if (req_chan.valid && req_chan.ready) begin
            build_frame(req_chan.op, req_chan.value);
            frames_taken++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // driver: offer the next frame at the falling edge, with random gaps
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      frame_req_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.op    <= MODE_BARE;
         req_chan.value <= '0;
      end else if (!req_chan.valid || req_taken) begin
         if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = frame_q.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.op    <= nxt.op;
            req_chan.value <= nxt.value;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still owed", cycle_count,
                  line_q.size());
         $display("serial_line_frame_transmitter_top test failed");
         $finish;
      end
   end

   task automatic queue_frame(input logic op, input logic [VALUE_W-1:0] value);
      frame_q.push_back('{op: op, value: value});
      frames_queued++;
   endtask

   // mostly uniform words, now and then a corner pattern
   task automatic queue_random(input int count);
      logic [VALUE_W-1:0] val;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(7))
            0: val = '0;
            1: val = '1;
            2: val = VALUE_W'(1) << $urandom_range(VALUE_W - 1);
            default: val = $urandom;
         endcase
         queue_frame(($urandom_range(1) == 0) ? MODE_BARE : MODE_UART, val);
      end
   endtask

   // every queued frame taken and every owed word back; read at the falling
   // edge so the monitor has settled
   task automatic wait_idle();
      do @(negedge clock);
      while (frames_taken != frames_queued || line_q.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_PERIOD_MS)
         cfg_period_ms = data[PERIOD_W-1:0];
      else
         cfg_clk_per_ms = data[MS_W-1:0];
   endtask

   // drain, retime the bit and set the idle mix for the next stretch
   task automatic start_phase(input int period, input int ms, input int send_pct,
                              input int recv_pct);
      wait_idle();
      repeat (4) @(negedge clock);
      write_reg(CSR_PERIOD_MS, CSR_DATA_W'(period));
      write_reg(CSR_CLK_PER_MS, CSR_DATA_W'(ms));
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      settings_run++;
      $display("bit time %0d ms x %0d cycles, sender idle %0d%%, receiver idle %0d%%",
               cfg_period_ms, cfg_clk_per_ms, send_pct, recv_pct);
   endtask

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_PERIOD_MS;
      csr_wdata      = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: shortest bit time, sender idles seldom, receiver often
      start_phase(1, 1, 17, 78);
      queue_frame(MODE_BARE, 32'h0000_0000);
      queue_frame(MODE_BARE, 32'hFFFF_FFFF);
      queue_frame(MODE_BARE, 32'h8000_0001);
      queue_frame(MODE_BARE, 32'hAAAA_AAAA);
      queue_frame(MODE_BARE, 32'h5555_5555);
      queue_frame(MODE_UART, 32'h0000_0000);
      queue_frame(MODE_UART, 32'h0000_00FF);
      queue_frame(MODE_UART, 32'h0000_00A5);
      // upper bits must not leak into a uart frame
      queue_frame(MODE_UART, 32'hFFFF_FF00);
      queue_frame(MODE_UART, 32'h1234_56C3);
      queue_frame(MODE_BARE, 32'hDEAD_BEEF);
      queue_frame(MODE_UART, 32'hFFFF_FFFF);
      // bare right after uart and the other way round
      queue_frame(MODE_BARE, 32'h0000_0001);
      queue_frame(MODE_UART, 32'h0000_0080);

      start_phase(2, 3, 17, 78);
      queue_random(35);

      // sender idles often, receiver seldom
      start_phase(3, 2, 78, 17);
      queue_random(35);

      // no idling from here on; longest period, one uart frame only
      start_phase(65535, 1, 0, 0);
      queue_frame(MODE_UART, 32'h0000_0096);

      start_phase(1, 5, 0, 0);
      queue_random(30);

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (line_q.size() != 0)
         report_mismatch($sformatf("%0d line words never came back", line_q.size()));
      $display("sent %0d bare and %0d uart frames over %0d bit-time settings",
               bare_frames, uart_frames, settings_run);
      $display("checked %0d line words, %0d mismatches", words_checked, err_count);
      if (err_count == 0) begin
         $display("serial_line_frame_transmitter_top test passed");
      end else begin
         $display("serial_line_frame_transmitter_top test failed");
      end
      $finish;
   end

endmodule
